// ----- rtl/core/pbpc_pkg.sv -----
package pbpc_pkg;
    localparam int HistDepth  = 10;
    localparam int HistAw     = 4;
    localparam int PosW       = 11;
    localparam int SumW       = 16;
    localparam int FifW       = 16;
    localparam int VelBack    = 5;
    localparam int RejectSum  = 675;  // sum/9 >= 75
    localparam int StillSum   = 10;
    localparam int StillCnt   = 30;
    localparam int VelLim     = 25;
    localparam int ServoMax   = 4095;
    localparam logic [15:0] RecipFive = 16'd52429;  // 2^18 / 5, rounded up
    localparam logic [9:0]  TargetRst = 10'd290;
    localparam logic [11:0] TrimXRst  = 12'd1584;
    localparam logic [11:0] TrimYRst  = 12'd1458;

    localparam logic [1:0] StRun = 2'd0;
    localparam logic [1:0] StBal = 2'd1;
    localparam logic [1:0] StRej = 2'd2;

    localparam logic [1:0] RegTgtX  = 2'd0;
    localparam logic [1:0] RegTgtY  = 2'd1;
    localparam logic [1:0] RegTrimX = 2'd2;
    localparam logic [1:0] RegTrimY = 2'd3;

    typedef struct packed {
        logic              we;
        logic [HistAw-1:0] waddr;
        logic [HistAw-1:0] raddr;
    } t_mem_ctl;

    // fifths / 5 truncated toward zero, saturated to 0..4095
    // negative input always gives 0; otherwise f * 52429 >> 18 is exact f / 5
    function automatic logic [11:0] to_servo(input logic signed [FifW-1:0] f);
        logic [FifW+17:0] prod;
        logic [FifW-1:0]  q;
        begin
            prod = (FifW+18)'(f[FifW-2:0]) * (FifW+18)'(RecipFive);
            q    = prod[FifW+17:18];
            if (f[FifW-1]) to_servo = 12'd0;
            else if (q > 16'(ServoMax)) to_servo = 12'(ServoMax);
            else to_servo = q[11:0];
        end
    endfunction
endpackage

// ----- rtl/core/pbpc_hist_mem.sv -----
module pbpc_hist_mem (
    input  logic                           i_clk,
    input  pbpc_pkg::t_mem_ctl             i_ctl,
    input  logic signed [2*pbpc_pkg::PosW-1:0] i_wdata,
    output logic signed [2*pbpc_pkg::PosW-1:0] o_rdata
);
    import pbpc_pkg::*;
    logic [2*PosW-1:0] r_mem [HistDepth];

    // one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_ctl.we) r_mem[i_ctl.waddr] <= i_wdata;
        o_rdata <= r_mem[i_ctl.raddr];
    end
endmodule

// ----- rtl/core/pbpc_axis.sv -----
module pbpc_axis (
    input  logic [11:0]                      i_trim,
    input  logic [9:0]                       i_target,
    input  logic signed [pbpc_pkg::PosW-1:0] i_pos,
    input  logic signed [5:0]                i_vel,
    input  logic signed [pbpc_pkg::FifW-1:0] i_last,
    input  logic                             i_slew,
    output logic signed [pbpc_pkg::FifW-1:0] o_cmd
);
    import pbpc_pkg::*;
    logic signed [19:0] off, s, d, last_w;
    logic signed [1:0]  so, sv, sd;

    // 5*trim + 4*off - 32*vel, brake tilt, slew limit (all in fifths)
    always_comb begin
        off    = 20'(signed'({1'b0, i_target})) - 20'(i_pos);
        so     = (off > 0) ? 2'sd1 : ((off < 0) ? -2'sd1 : 2'sd0);
        sv     = (i_vel > 0) ? 2'sd1 : ((i_vel < 0) ? -2'sd1 : 2'sd0);
        s      = 20'(signed'({1'b0, i_trim})) * 20'sd5 + (off <<< 2) - (20'(i_vel) <<< 5);
        if (so == sv) s = s + 20'(sv) * 20'sd50;
        last_w = 20'(i_last);
        d      = last_w - s;
        sd     = (d > 0) ? 2'sd1 : -2'sd1;
        if (i_slew && (d > 100 || d < -100)) s = last_w - 20'(sd) * 20'sd100;
        o_cmd  = s[FifW-1:0];
    end
endmodule

// ----- rtl/core/plate_ball_position_controller_unit.sv -----
// Flow: a sample that reaches the servo law passes the states SCAN (the ten raw
// entries through the registered read), EVAL, VEL, CMD and CONV before its result;
// rejected or balanced samples leave from EVAL, warm-up samples from IDLE or VEL.
// A new position transaction is accepted only in IDLE, after the last result has
// been taken; a trim command is applied in IDLE and leaves the unit ready.
// Reset: synchronous, active low; histories empty (fill counts zero), no clearing.
module plate_ball_position_controller_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic                             i_command,
    input  logic signed [pbpc_pkg::PosW-1:0] i_pos_x,
    input  logic signed [pbpc_pkg::PosW-1:0] i_pos_y,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [1:0]                       o_status,
    output logic                             o_servo_valid,
    output logic [11:0]                      o_servo_x,
    output logic [11:0]                      o_servo_y,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [1:0]                       i_cfg_index,
    input  logic [11:0]                      i_cfg_data
);
    import pbpc_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_EVAL, S_VEL, S_CMD, S_CONV, S_OUT} t_state;
    t_state r_state;

    logic [9:0]  r_tgt_x, r_tgt_y;
    logic [11:0] r_itrim_x, r_itrim_y, r_trim_x, r_trim_y;
    logic signed [PosW-1:0] r_x, r_y;
    logic [HistAw-1:0] r_raw_head, r_raw_fill, r_val_head, r_val_fill, r_vel_fill;
    logic [HistAw-1:0] r_cnt;
    logic [7:0]  r_still;
    logic signed [FifW-1:0] r_last_x, r_last_y;
    logic [SumW-1:0] r_sum;
    logic        r_scan_on;
    logic signed [5:0] r_vx, r_vy;
    logic [1:0]  r_status;
    logic        r_sv;
    logic [11:0] r_so_x, r_so_y;

    t_mem_ctl raw_ctl, val_ctl;
    logic signed [2*PosW-1:0] raw_rd, val_rd;
    logic signed [PosW-1:0] hx, hy;
    logic signed [PosW:0] dx, dy, adx, ady, dmax;
    logic signed [PosW:0] vx_f, vy_f;
    logic signed [FifW-1:0] cmd_x, cmd_y;
    logic [7:0] still_n;
    logic [11:0] lvl_x, lvl_y;

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = (r_state == S_OUT);
    assign o_status      = r_status;
    assign o_servo_valid = r_sv;
    assign o_servo_x     = r_so_x;
    assign o_servo_y     = r_so_y;

    // memory controls
    always_comb begin
        raw_ctl.we    = o_ready && i_valid && !i_command;
        raw_ctl.waddr = r_raw_head;
        raw_ctl.raddr = r_cnt;
        val_ctl.we    = 1'b0;
        val_ctl.waddr = r_val_head;
        val_ctl.raddr = (r_val_head >= HistAw'(VelBack)) ?
                        r_val_head - HistAw'(VelBack) :
                        r_val_head + HistAw'(HistDepth - VelBack);
        if (r_state == S_EVAL) val_ctl.we = 1'b1;
    end

    pbpc_hist_mem u_raw (.i_clk, .i_ctl(raw_ctl), .i_wdata({i_pos_x, i_pos_y}),
                         .o_rdata(raw_rd));
    pbpc_hist_mem u_val (.i_clk, .i_ctl(val_ctl), .i_wdata({r_x, r_y}),
                         .o_rdata(val_rd));

    // Chebyshev distance of current read entry
    always_comb begin
        hx   = raw_rd[2*PosW-1:PosW];
        hy   = raw_rd[PosW-1:0];
        dx   = 12'(r_x) - 12'(hx);
        dy   = 12'(r_y) - 12'(hy);
        adx  = dx[PosW] ? -dx : dx;
        ady  = dy[PosW] ? -dy : dy;
        dmax = (adx > ady) ? adx : ady;
        vx_f = 12'(r_x) - 12'(signed'(val_rd[2*PosW-1:PosW]));
        vy_f = 12'(r_y) - 12'(signed'(val_rd[PosW-1:0]));
        still_n = r_still + 8'd1;
    end

    // servo levels of the last commands
    always_comb begin
        lvl_x = to_servo(r_last_x);
        lvl_y = to_servo(r_last_y);
    end

    pbpc_axis u_ax (.i_trim(r_trim_x), .i_target(r_tgt_x), .i_pos(r_x), .i_vel(r_vx),
                    .i_last(r_last_x), .i_slew(r_last_x > 0), .o_cmd(cmd_x));
    pbpc_axis u_ay (.i_trim(r_trim_y), .i_target(r_tgt_y), .i_pos(r_y), .i_vel(r_vy),
                    .i_last(r_last_y), .i_slew(r_last_x > 0), .o_cmd(cmd_y));

    // control and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tgt_x <= TargetRst; r_tgt_y <= TargetRst;
            r_itrim_x <= TrimXRst; r_itrim_y <= TrimYRst;
            r_trim_x <= TrimXRst; r_trim_y <= TrimYRst;
            r_raw_head <= '0; r_raw_fill <= '0;
            r_val_head <= '0; r_val_fill <= '0; r_vel_fill <= '0;
            r_still <= '0; r_last_x <= '0; r_last_y <= '0;
            r_cnt <= '0; r_scan_on <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    RegTgtX:  r_tgt_x   <= i_cfg_data[9:0];
                    RegTgtY:  r_tgt_y   <= i_cfg_data[9:0];
                    RegTrimX: r_itrim_x <= i_cfg_data;
                    RegTrimY: r_itrim_y <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        if (i_command) begin
                            r_trim_x <= r_itrim_x; r_trim_y <= r_itrim_y;
                        end else begin
                            r_x <= i_pos_x; r_y <= i_pos_y;
                            r_raw_head <= (r_raw_head == HistAw'(HistDepth - 1)) ?
                                          '0 : r_raw_head + 1'b1;
                            r_status <= StRun; r_sv <= 1'b0;
                            r_so_x <= '0; r_so_y <= '0;
                            if (r_raw_fill < HistAw'(HistDepth - 1)) begin
                                r_raw_fill <= r_raw_fill + 1'b1;
                                r_state <= S_OUT;
                            end else begin
                                r_raw_fill <= HistAw'(HistDepth);
                                r_cnt <= '0; r_sum <= '0; r_scan_on <= 1'b0;
                                r_state <= S_SCAN;
                            end
                        end
                    end
                end
                S_SCAN: begin
                    // one read per cycle; data for previous address arrives now
                    if (r_scan_on) r_sum <= r_sum + SumW'(dmax);
                    r_scan_on <= 1'b1;
                    if (r_cnt == HistAw'(HistDepth)) r_state <= S_EVAL;
                    else r_cnt <= r_cnt + 1'b1;
                end
                S_EVAL: begin
                    r_state <= S_VEL;
                    if (r_sum >= SumW'(RejectSum)) begin
                        r_status <= StRej; r_state <= S_OUT;
                    end else if (r_sum <= SumW'(StillSum)) begin
                        r_still <= still_n;
                        if (still_n == 8'(StillCnt)) begin
                            r_trim_x <= lvl_x;
                            r_trim_y <= lvl_y;
                            r_status <= StBal; r_state <= S_OUT;
                        end
                    end else begin
                        r_still <= '0;
                    end
                end
                S_VEL: begin
                    // valid history written in EVAL; back entry read now
                    r_val_head <= (r_val_head == HistAw'(HistDepth - 1)) ?
                                  '0 : r_val_head + 1'b1;
                    r_vx <= (vx_f > VelLim) ? 6'sd25 : (vx_f < -VelLim) ? -6'sd25 : 6'(vx_f);
                    r_vy <= (vy_f > VelLim) ? 6'sd25 : (vy_f < -VelLim) ? -6'sd25 : 6'(vy_f);
                    if (r_val_fill < HistAw'(HistDepth - 1)) begin
                        r_val_fill <= r_val_fill + 1'b1; r_state <= S_OUT;
                    end else begin
                        r_val_fill <= HistAw'(HistDepth);
                        if (r_vel_fill < HistAw'(HistDepth - 1)) begin
                            r_vel_fill <= r_vel_fill + 1'b1; r_state <= S_OUT;
                        end else begin
                            r_vel_fill <= HistAw'(HistDepth);
                            r_state <= S_CMD;
                        end
                    end
                end
                S_CMD: begin
                    r_last_x <= cmd_x; r_last_y <= cmd_y;
                    r_sv <= 1'b1;
                    r_state <= S_CONV;
                end
                S_CONV: begin
                    // servo levels from the new commands
                    r_so_x <= lvl_x; r_so_y <= lvl_y;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
